// ----- rtl/tsp_matrix_reduction_bound_top_assert.svh -----
// Assertion macros for the matrix reduction bound block
`ifndef TSP_MATRIX_REDUCTION_BOUND_TOP_ASSERT_SVH
`define TSP_MATRIX_REDUCTION_BOUND_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TMRB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tmrb assertion failed");

// next-cycle implication, checked out of reset
`define TMRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tmrb assertion failed");

`endif

// ----- rtl/tmrb_pkg.sv -----
package tmrb_pkg;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_BLOCK,
        CMD_ROWMIN,
        CMD_ROWSUB,
        CMD_COLMIN,
        CMD_COLSUB,
        CMD_SUM
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      root;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_ROOT   = 2'd2,
        OP_BRANCH = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_EDGE,
        ST_BLOCK,
        ST_ROWMIN,
        ST_ROWSUB,
        ST_COLMIN,
        ST_COLSUB,
        ST_SUM,
        ST_DONE
    } t_state;

    localparam int BOUND_W = 38;

endpackage

// ----- rtl/tsp_matrix_reduction_bound_top.sv -----
// Channel    | Ports                                                    | Handshake
// -----------+----------------------------------------------------------+--------------------
// command    | i_opcode i_row_index i_col_index i_entry_value           | i_start & !o_busy
// result     | o_read_value o_bound_increment o_increment_infinite      | o_done, one cycle
// config     | i_cfg_data (size_in_use)                                 | i_cfg_we
//
// Transaction steps (N = MAX_VERTICES, n = size in use):
//   write, read: accept, access, result; out-of-range branch: accept, result.
//   root: block, row min/sub per row, col min, col sub, sum; branch reads its edge first.
//   The row pass dominates: each row minimum ripples through all N cells.
// Reset clears the control state and sets the size to 16; matrix holds no reset.
// No stalls: o_busy is high from acceptance until the result strobe.
module tsp_matrix_reduction_bound_top #(
    parameter int MAX_VERTICES = 16,
    parameter int DIST_WIDTH   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_row_index,
    input  logic [3:0]  i_col_index,
    input  logic [31:0] i_entry_value,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    output logic        o_done,
    output logic [31:0] o_read_value,
    output logic [37:0] o_bound_increment,
    output logic        o_increment_infinite
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES+1);
    localparam int BW    = tmrb_pkg::BOUND_W;
    localparam logic [DIST_WIDTH-1:0] INF = {DIST_WIDTH{1'b1}};

    tmrb_pkg::t_state r_state, n_state;

    logic [4:0]            r_size;
    logic [1:0]            r_op;
    logic [3:0]            r_r;
    logic [3:0]            r_c;
    logic [DIST_WIDTH-1:0] r_val;
    logic [CNT_W-1:0]      r_k;
    logic [CNT_W-1:0]      r_cyc;
    logic [BW-1:0]         r_total;
    logic [31:0]           r_read;
    logic                  r_flag;

    logic [CNT_W-1:0]      w_n;
    logic                  w_k_last;
    logic                  w_cyc_last;
    logic                  w_sum_last;
    logic                  w_in_store;
    logic                  w_in_use;
    tmrb_pkg::t_cell_ctrl  w_ctrl;
    logic [IDX_W-1:0]      w_idx;
    logic [IDX_W-1:0]      w_u;
    logic [IDX_W-1:0]      w_v;

    logic [DIST_WIDTH-1:0] w_min [MAX_VERTICES+1];
    logic [BW-1:0]         w_sum [MAX_VERTICES+1];
    logic [DIST_WIDTH-1:0] w_rd  [MAX_VERTICES];

    // size clamp: below 2 acts as 2, above the store acts as the store
    always_comb begin
        if (r_size < 5'd2) begin
            w_n = CNT_W'(2);
        end else if (32'(r_size) > 32'(MAX_VERTICES)) begin
            w_n = CNT_W'(MAX_VERTICES);
        end else begin
            w_n = CNT_W'(r_size);
        end
    end

    assign w_k_last   = (r_k == w_n - CNT_W'(1));
    assign w_cyc_last = (r_cyc == CNT_W'(MAX_VERTICES - 1));
    // the sum pass also waits for the token to leave the last cell's register
    assign w_sum_last = (r_cyc == CNT_W'(MAX_VERTICES));
    assign w_in_store = (32'(i_row_index) < 32'(MAX_VERTICES))
                     && (32'(i_col_index) < 32'(MAX_VERTICES));
    assign w_in_use   = (32'(i_row_index) < 32'(w_n)) && (32'(i_col_index) < 32'(w_n));
    assign w_u        = IDX_W'(r_r);
    assign w_v        = IDX_W'(r_c);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tmrb_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_opcode)
                        tmrb_pkg::OP_WRITE:  n_state = w_in_store ? tmrb_pkg::ST_WRITE
                                                                  : tmrb_pkg::ST_DONE;
                        tmrb_pkg::OP_READ:   n_state = w_in_store ? tmrb_pkg::ST_READ
                                                                  : tmrb_pkg::ST_DONE;
                        tmrb_pkg::OP_ROOT:   n_state = tmrb_pkg::ST_BLOCK;
                        default:             n_state = w_in_use ? tmrb_pkg::ST_EDGE
                                                                : tmrb_pkg::ST_DONE;
                    endcase
                end
            end
            tmrb_pkg::ST_WRITE:  n_state = tmrb_pkg::ST_DONE;
            tmrb_pkg::ST_READ:   n_state = tmrb_pkg::ST_DONE;
            tmrb_pkg::ST_EDGE:   n_state = tmrb_pkg::ST_BLOCK;
            tmrb_pkg::ST_BLOCK:  if (w_k_last) n_state = tmrb_pkg::ST_ROWMIN;
            tmrb_pkg::ST_ROWMIN: if (w_cyc_last) n_state = tmrb_pkg::ST_ROWSUB;
            tmrb_pkg::ST_ROWSUB: n_state = w_k_last ? tmrb_pkg::ST_COLMIN
                                                    : tmrb_pkg::ST_ROWMIN;
            tmrb_pkg::ST_COLMIN: if (w_k_last) n_state = tmrb_pkg::ST_COLSUB;
            tmrb_pkg::ST_COLSUB: if (w_k_last) n_state = tmrb_pkg::ST_SUM;
            tmrb_pkg::ST_SUM:    if (w_sum_last) n_state = tmrb_pkg::ST_DONE;
            tmrb_pkg::ST_DONE:   n_state = tmrb_pkg::ST_IDLE;
            default:             n_state = tmrb_pkg::ST_IDLE;
        endcase
    end

    // cell commands and handshake outputs
    always_comb begin
        w_ctrl.cmd  = tmrb_pkg::CMD_NONE;
        w_ctrl.root = (r_op == tmrb_pkg::OP_ROOT);
        w_idx       = IDX_W'(r_k);
        case (r_state)
            tmrb_pkg::ST_WRITE: begin
                w_ctrl.cmd = tmrb_pkg::CMD_WRITE;
                w_idx      = w_u;
            end
            tmrb_pkg::ST_READ,
            tmrb_pkg::ST_EDGE:   w_idx = w_u;
            tmrb_pkg::ST_BLOCK:  w_ctrl.cmd = tmrb_pkg::CMD_BLOCK;
            tmrb_pkg::ST_ROWMIN: w_ctrl.cmd = tmrb_pkg::CMD_ROWMIN;
            tmrb_pkg::ST_ROWSUB: w_ctrl.cmd = tmrb_pkg::CMD_ROWSUB;
            tmrb_pkg::ST_COLMIN: w_ctrl.cmd = tmrb_pkg::CMD_COLMIN;
            tmrb_pkg::ST_COLSUB: w_ctrl.cmd = tmrb_pkg::CMD_COLSUB;
            tmrb_pkg::ST_SUM:    w_ctrl.cmd = tmrb_pkg::CMD_SUM;
            default: begin
            end
        endcase
    end

    assign o_busy               = (r_state != tmrb_pkg::ST_IDLE);
    assign o_done               = (r_state == tmrb_pkg::ST_DONE);
    assign o_read_value         = r_read;
    assign o_bound_increment    = r_total;
    assign o_increment_infinite = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmrb_pkg::ST_IDLE;
            r_size  <= 5'd16;
            r_k     <= '0;
            r_cyc   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_size <= i_cfg_data;
            case (r_state)
                tmrb_pkg::ST_IDLE: begin
                    r_k   <= '0;
                    r_cyc <= '0;
                end
                tmrb_pkg::ST_BLOCK,
                tmrb_pkg::ST_ROWSUB,
                tmrb_pkg::ST_COLMIN,
                tmrb_pkg::ST_COLSUB: r_k <= w_k_last ? '0 : r_k + CNT_W'(1);
                tmrb_pkg::ST_ROWMIN: r_cyc <= w_cyc_last ? '0 : r_cyc + CNT_W'(1);
                tmrb_pkg::ST_SUM:    r_cyc <= w_sum_last ? '0 : r_cyc + CNT_W'(1);
                default: begin
                end
            endcase
        end
    end

    // transaction payload and accumulators
    always_ff @(posedge i_clk) begin
        case (r_state)
            tmrb_pkg::ST_IDLE: begin
                r_op    <= i_opcode;
                r_r     <= i_row_index;
                r_c     <= i_col_index;
                r_val   <= DIST_WIDTH'(i_entry_value);
                r_total <= '0;
                r_read  <= '0;
                r_flag  <= 1'b0;
            end
            tmrb_pkg::ST_READ:   r_read <= 32'(w_rd[w_v]);
            tmrb_pkg::ST_EDGE: begin
                if (w_rd[w_v] == INF) r_flag <= 1'b1;
                else                  r_total <= BW'(w_rd[w_v]);
            end
            tmrb_pkg::ST_ROWSUB: begin
                if (w_min[MAX_VERTICES] != INF) begin
                    r_total <= r_total + BW'(w_min[MAX_VERTICES]);
                end
            end
            tmrb_pkg::ST_SUM: begin
                if (w_sum_last) r_total <= r_total + w_sum[MAX_VERTICES];
            end
            default: begin
            end
        endcase
    end

    // chain of column cells; min and sum tokens ripple left to right
    assign w_min[0] = INF;
    assign w_sum[0] = '0;

    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        tmrb_cell #(
            .MAX_VERTICES (MAX_VERTICES),
            .DIST_WIDTH   (DIST_WIDTH),
            .CELL_ID      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_idx   (w_idx),
            .i_u     (w_u),
            .i_v     (w_v),
            .i_n     (w_n),
            .i_wdata (r_val),
            .i_lo    (w_min[MAX_VERTICES]),
            .i_min   (w_min[g]),
            .o_min   (w_min[g+1]),
            .i_sum   (w_sum[g]),
            .o_sum   (w_sum[g+1]),
            .o_rd    (w_rd[g])
        );
    end

`include "tsp_matrix_reduction_bound_top_assert.svh"

    `TMRB_ASSERT_NOW(a_done_while_busy, o_done, o_busy)
    `TMRB_ASSERT_NEXT(a_accept_goes_busy, i_start && !o_busy, o_busy)
    `TMRB_ASSERT_NEXT(a_done_one_cycle, o_done, !o_done && !o_busy)

endmodule

// ----- rtl/tmrb_cell.sv -----
// One column of the cost matrix plus its slice of the min and sum chains.
module tmrb_cell #(
    parameter int MAX_VERTICES = 16,
    parameter int DIST_WIDTH   = 32,
    parameter int CELL_ID      = 0
) (
    input  logic                                i_clk,
    input  tmrb_pkg::t_cell_ctrl                i_ctrl,
    input  logic [$clog2(MAX_VERTICES)-1:0]     i_idx,
    input  logic [$clog2(MAX_VERTICES)-1:0]     i_u,
    input  logic [$clog2(MAX_VERTICES)-1:0]     i_v,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]   i_n,
    input  logic [DIST_WIDTH-1:0]               i_wdata,
    input  logic [DIST_WIDTH-1:0]               i_lo,
    input  logic [DIST_WIDTH-1:0]               i_min,
    output logic [DIST_WIDTH-1:0]               o_min,
    input  logic [tmrb_pkg::BOUND_W-1:0]        i_sum,
    output logic [tmrb_pkg::BOUND_W-1:0]        o_sum,
    output logic [DIST_WIDTH-1:0]               o_rd
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES+1);
    localparam logic [DIST_WIDTH-1:0] INF = {DIST_WIDTH{1'b1}};
    localparam logic [IDX_W-1:0] ID = IDX_W'(CELL_ID);

    logic [DIST_WIDTH-1:0] r_mem [MAX_VERTICES];
    logic [DIST_WIDTH-1:0] r_lo;
    logic [DIST_WIDTH-1:0] r_min;
    logic [tmrb_pkg::BOUND_W-1:0] r_sum;

    logic                  w_active;
    logic                  w_block;
    logic [DIST_WIDTH-1:0] w_ent;

    assign w_ent    = r_mem[i_idx];
    assign o_rd     = w_ent;
    assign o_min    = r_min;
    assign o_sum    = r_sum;
    assign w_active = CNT_W'(CELL_ID) < i_n;

    always_comb begin
        if (i_ctrl.root) begin
            w_block = (i_idx == ID);
        end else begin
            w_block = (ID == i_v) || (i_idx == i_u) || ((CELL_ID == 0) && (i_idx == i_v));
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            tmrb_pkg::CMD_WRITE: begin
                if (i_v == ID) r_mem[i_idx] <= i_wdata;
            end
            tmrb_pkg::CMD_BLOCK: begin
                if (w_active && w_block) r_mem[i_idx] <= INF;
            end
            tmrb_pkg::CMD_ROWMIN: begin
                r_min <= (w_active && (w_ent < i_min)) ? w_ent : i_min;
            end
            tmrb_pkg::CMD_ROWSUB: begin
                if (w_active && (w_ent != INF)) r_mem[i_idx] <= w_ent - i_lo;
            end
            tmrb_pkg::CMD_COLMIN: begin
                if (i_idx == '0 || w_ent < r_lo) r_lo <= w_ent;
            end
            tmrb_pkg::CMD_COLSUB: begin
                if (w_active && (w_ent != INF)) r_mem[i_idx] <= w_ent - r_lo;
            end
            tmrb_pkg::CMD_SUM: begin
                if (w_active && (r_lo != INF)) begin
                    r_sum <= i_sum + tmrb_pkg::BOUND_W'(r_lo);
                end else begin
                    r_sum <= i_sum;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
